### src/spdt_pkg.sv
// Shared types and constants for the spike pair dissimilarity term unit.
// Used by the log2 pipeline, the divider pipeline and the top level.
`default_nettype none

package spdt_pkg;

	localparam int TIME_W       = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_FRAC     = 24;
	localparam int MANT_BITS    = 30;
	localparam int LOG_LAT      = LOG_FRAC + 3;
	localparam int DIV_LAT      = 32;
	localparam int X_W          = TIME_W + 2;
	localparam int G_W          = TIME_W + 1;
	localparam int DMAG_W       = 31;
	localparam int NUM_W        = 64;
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

	typedef struct packed {
		logic [TIME_W-1:0] spike_time_a;
		logic [TIME_W-1:0] spike_time_b;
		logic [TIME_W-1:0] interval_start;
		logic [TIME_W-1:0] interval_end;
		logic [TIME_W-1:0] interval_length;
		logic [TIME_W-1:0] near_dist_a;
		logic [TIME_W-1:0] near_dist_b;
	} item_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] term_value;
		logic                     invalid;
	} result_t;

	// Sideband that rides along the log2 pipelines.
	typedef struct packed {
		logic              eq;
		logic              inv;
		logic              ze;
		logic              zs;
		logic [G_W-1:0]    g;
		logic [TIME_W-1:0] len;
	} side_t;

	// Sideband that rides along the divider.
	typedef struct packed {
		logic eq;
		logic inv;
		logic neg;
		logic ovf;
	} dside_t;

endpackage

`default_nettype wire

### src/spike_pair_dissimilarity_term_unit.sv
// Spike pair dissimilarity term unit. Takes one request per clock while the skid
// register is empty and returns one result per request, in order, through 2 front
// stages, two 27-stage log2 pipelines running side by side (one squaring
// multiplier per fraction bit), 4 stages for the log difference, ln2 scale, gap
// product and overflow check, a 32-stage restoring divider, and the output
// register. A skid register behind the output takes one more result when the
// consumer stalls; the pipeline holds while the skid is full.
// Depends on spdt_pkg, spdt_log2 and spdt_div.
`default_nettype none

module spike_pair_dissimilarity_term_unit #(
	parameter int FRAC_BITS = spdt_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire spdt_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output spdt_pkg::result_t     result
);

	localparam int TW  = spdt_pkg::TIME_W;
	localparam int SH  = 26 - FRAC_BITS;
	localparam int DW  = TW + SH;
	localparam int LL  = spdt_pkg::LOG_LAT;
	localparam int DL  = spdt_pkg::DIV_LAT;
	localparam int XW  = spdt_pkg::X_W;

	logic en;
	logic skid_vld_q;
	spdt_pkg::result_t skid_q;
	logic out_vld_q;
	spdt_pkg::result_t out_q;

	assign en         = !skid_vld_q;
	assign item_ready = en;

	// stage 1: sum, gap, nearest distance of the earlier train
	logic          vld_s1;
	logic [TW:0]   sum_s1;
	logic [TW-1:0] gap_s1, near_s1, ts_s1, te_s1, len_s1;
	logic          eq_s1;
	logic          a_lt_b;

	assign a_lt_b = item.spike_time_a < item.spike_time_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= {1'b0, item.spike_time_a} + {1'b0, item.spike_time_b};
			gap_s1  <= a_lt_b ? item.spike_time_b - item.spike_time_a
			                  : item.spike_time_a - item.spike_time_b;
			near_s1 <= a_lt_b ? item.near_dist_a : item.near_dist_b;
			eq_s1   <= item.spike_time_a == item.spike_time_b;
			ts_s1   <= item.interval_start;
			te_s1   <= item.interval_end;
			len_s1  <= item.interval_length;
		end
	end

	// stage 2: log arguments and flags
	logic signed [XW:0] xe_c, xs_c;
	assign xe_c = $signed({2'b00, te_s1, 1'b0}) - $signed({2'b00, sum_s1});
	assign xs_c = $signed({2'b00, ts_s1, 1'b0}) - $signed({2'b00, sum_s1});

	logic            vld_s2;
	logic [XW-1:0]   xe_s2, xs_s2;
	spdt_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xe_s2       <= xe_c[XW-1:0];
			xs_s2       <= xs_c[XW-1:0];
			side_s2.eq  <= eq_s1;
			side_s2.inv <= !eq_s1 && (xe_c[XW] || xs_c[XW] || len_s1 == '0);
			side_s2.ze  <= xe_c == '0;
			side_s2.zs  <= xs_c == '0;
			side_s2.g   <= {1'b0, gap_s1} + {1'b0, near_s1};
			side_s2.len <= len_s1;
		end
	end

	// log2 pipelines with matching sideband delay
	logic signed [31:0] le_w, ls_w;

	spdt_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_end (
		.clk(clk), .en(en), .x(xe_s2), .le(le_w)
	);

	spdt_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_start (
		.clk(clk), .en(en), .x(xs_s2), .le(ls_w)
	);

	logic            vld_l[LL];
	spdt_pkg::side_t side_l[LL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LL; i++) vld_l[i] <= 1'b0;
		end else if (en) begin
			vld_l[0] <= vld_s2;
			for (int i = 1; i < LL; i++) vld_l[i] <= vld_l[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_l[0] <= side_s2;
			for (int i = 1; i < LL; i++) side_l[i] <= side_l[i-1];
		end
	end

	// stage 3: log difference, sign and magnitude
	spdt_pkg::side_t side_t_end;
	logic signed [31:0] le_e, ls_e, d_c, dn_c;
	assign side_t_end = side_l[LL-1];
	assign le_e = side_t_end.ze ? 32'sd0 : le_w;
	assign ls_e = side_t_end.zs ? 32'sd0 : ls_w;
	assign d_c  = le_e - ls_e;
	assign dn_c = -d_c;

	logic                        vld_s3, neg_s3, eq_s3, inv_s3;
	logic [spdt_pkg::DMAG_W-1:0] dmag_s3;
	logic [spdt_pkg::G_W-1:0]    g_s3;
	logic [TW-1:0]               len_s3;

	// stage 4: scale by ln 2
	logic                        vld_s4, neg_s4, eq_s4, inv_s4;
	logic [62:0]                 prod_s4;
	logic [spdt_pkg::G_W-1:0]    g_s4;
	logic [TW-1:0]               len_s4;

	// stage 5: gap times ln difference
	logic                        vld_s5, neg_s5, eq_s5, inv_s5;
	logic [spdt_pkg::NUM_W-1:0]  num_s5;
	logic [TW-1:0]               len_s5;

	// stage 6: divisor, overflow check, initial remainder
	logic                        vld_s6;
	spdt_pkg::dside_t            ds_s6;
	logic [DW-1:0]               den_s6, r0_s6;
	logic [31:0]                 lo_s6;
	logic [DW-1:0]               den_c;
	assign den_c = {len_s5, {SH{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_l[LL-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= d_c[31];
			dmag_s3 <= d_c[31] ? dn_c[spdt_pkg::DMAG_W-1:0] : d_c[spdt_pkg::DMAG_W-1:0];
			eq_s3   <= side_t_end.eq;
			inv_s3  <= side_t_end.inv;
			g_s3    <= side_t_end.g;
			len_s3  <= side_t_end.len;

			prod_s4 <= dmag_s3 * spdt_pkg::LN2_Q32;
			neg_s4  <= neg_s3;
			eq_s4   <= eq_s3;
			inv_s4  <= inv_s3;
			g_s4    <= g_s3;
			len_s4  <= len_s3;

			num_s5  <= g_s4 * prod_s4[62:32];
			neg_s5  <= neg_s4;
			eq_s5   <= eq_s4;
			inv_s5  <= inv_s4;
			len_s5  <= len_s4;

			den_s6    <= den_c;
			r0_s6     <= DW'(num_s5[63:32]);
			lo_s6     <= num_s5[31:0];
			ds_s6.ovf <= DW'(num_s5[63:32]) >= den_c;
			ds_s6.neg <= neg_s5;
			ds_s6.eq  <= eq_s5;
			ds_s6.inv <= inv_s5;
		end
	end

	// divider with matching sideband delay
	logic [31:0] q_w;

	spdt_div #(.DW(DW)) u_div (
		.clk(clk), .en(en), .r0(r0_s6), .lo(lo_s6), .den(den_s6), .q(q_w)
	);

	logic             vld_d[DL];
	spdt_pkg::dside_t ds_d[DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) vld_d[i] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld_s6;
			for (int i = 1; i < DL; i++) vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_d[0] <= ds_s6;
			for (int i = 1; i < DL; i++) ds_d[i] <= ds_d[i-1];
		end
	end

	// sign and saturation
	spdt_pkg::dside_t  ds_end;
	spdt_pkg::result_t p_data;
	logic              p_vld;
	logic [31:0]       mag_c;

	assign ds_end = ds_d[DL-1];
	assign p_vld  = vld_d[DL-1];

	always_comb begin
		if (ds_end.neg) begin
			mag_c = (ds_end.ovf || q_w > 32'h8000_0000) ? 32'h8000_0000 : q_w;
			mag_c = 32'd0 - mag_c;
		end else begin
			mag_c = (ds_end.ovf || q_w[31]) ? 32'h7FFF_FFFF : q_w;
		end
		p_data.invalid    = ds_end.inv;
		p_data.term_value = (ds_end.eq || ds_end.inv) ? 32'sd0 : $signed(mag_c);
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !result_ready) begin
			if (en && p_vld) skid_vld_q <= 1'b1;
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= p_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !result_ready) begin
			if (en && p_vld) skid_q <= p_data;
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= p_data;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	// hold the skid only behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry without a pending result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.invalid |-> result.term_value == 32'sd0)
		else $error("invalid result carries a nonzero term");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		en && !item_valid |=> !vld_s1)
		else $error("stage 1 valid without an accepted request");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && result_ready |=> !skid_vld_q && out_vld_q)
		else $error("skid entry not moved to the output");

endmodule

`default_nettype wire

### src/spdt_log2.sv
// Pipelined log2 of X / 2^(FRAC_BITS+1), result signed with 24 fraction bits.
// One square-and-compare step per stage; uses spdt_pkg constants.
`default_nettype none

module spdt_log2 #(
	parameter int FRAC_BITS = spdt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [spdt_pkg::X_W-1:0]      x,
	output logic signed [31:0]                 le
);

	localparam int LF = spdt_pkg::LOG_FRAC;
	localparam int MB = spdt_pkg::MANT_BITS;

	logic [spdt_pkg::X_W-1:0] x_s1;
	logic [5:0]               k_s1;
	logic [5:0]               k_enc;

	logic [MB:0]   m_q   [LF+1];
	logic [LF-1:0] frac_q[LF+1];
	logic [5:0]    k_q   [LF+1];

	// leading one position
	always_comb begin
		k_enc = '0;
		for (int i = 0; i < spdt_pkg::X_W; i++) begin
			if (x[i]) k_enc = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			k_s1 <= k_enc;
		end
	end

	// normalize mantissa to Q1.30, truncating on a right shift
	logic [63:0] shl_w;
	logic [63:0] shr_w;
	assign shl_w = {{(64-spdt_pkg::X_W){1'b0}}, x_s1} << (6'(MB) - k_s1);
	assign shr_w = {{(64-spdt_pkg::X_W){1'b0}}, x_s1} >> (k_s1 - 6'(MB));

	always_ff @(posedge clk) begin
		if (en) begin
			m_q[0]    <= (k_s1 >= 6'(MB)) ? shr_w[MB:0] : shl_w[MB:0];
			frac_q[0] <= '0;
			k_q[0]    <= k_s1;
		end
	end

	for (genvar i = 0; i < LF; i++) begin : g_sq
		logic [2*MB+1:0] sq;
		logic [MB+1:0]   t;
		assign sq = m_q[i] * m_q[i];
		assign t  = sq[2*MB+1:MB];
		always_ff @(posedge clk) begin
			if (en) begin
				m_q[i+1]    <= t[MB+1] ? t[MB+1:1] : t[MB:0];
				frac_q[i+1] <= {frac_q[i][LF-2:0], t[MB+1]};
				k_q[i+1]    <= k_q[i];
			end
		end
	end

	logic signed [31:0] ip;
	assign ip = $signed({26'd0, k_q[LF]}) - 32'(FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			le <= (ip <<< LF) + $signed({{(32-LF){1'b0}}, frac_q[LF]});
		end
	end

endmodule

`default_nettype wire

### src/spdt_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32 quotient bits.
// The caller supplies the partial remainder already below the divisor.
`default_nettype none

module spdt_div #(
	parameter int DW = 42
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] r0,
	input  wire logic [31:0]   lo,
	input  wire logic [DW-1:0] den,
	output logic [31:0]        q
);

	localparam int N = spdt_pkg::DIV_LAT;

	logic [DW-1:0] r_q  [N+1];
	logic [31:0]   lo_q [N+1];
	logic [DW-1:0] den_q[N+1];
	logic [31:0]   q_q  [N+1];

	assign r_q[0]   = r0;
	assign lo_q[0]  = lo;
	assign den_q[0] = den;
	assign q_q[0]   = '0;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [DW:0] t;
		logic        ge;
		logic [DW:0] diff;
		assign t    = {r_q[i], lo_q[i][31]};
		assign ge   = t >= {1'b0, den_q[i]};
		assign diff = t - {1'b0, den_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i+1]   <= ge ? diff[DW-1:0] : t[DW-1:0];
				lo_q[i+1]  <= {lo_q[i][30:0], 1'b0};
				den_q[i+1] <= den_q[i];
				q_q[i+1]   <= {q_q[i][30:0], ge};
			end
		end
	end

	assign q = q_q[N];

endmodule

`default_nettype wire
